// ===== hdl/adsr_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the adsr envelope level block
// no dependencies

package adsr_pkg;

  localparam int LvlW    = 16;
  localparam int FracW   = 16;
  localparam int NoteW   = 24;
  localparam int ProdW   = FracW + NoteW;
  localparam int NumW    = 56;
  localparam int QuoW    = 16;
  localparam int SegW    = ProdW / 2;
  localparam int PartW   = FracW + SegW;
  localparam int CfgIdxW = 3;

  localparam logic [LvlW-1:0] FullScale = LvlW'(32768);

  // config register indexes
  localparam logic [CfgIdxW-1:0] RegAttack  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegDecay   = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegSustain = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegRelease = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegLevel   = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] RegNote    = CfgIdxW'(5);

  typedef enum logic [1:0] {
    MODE_DIRECT,
    MODE_ATTACK,
    MODE_DECAY,
    MODE_RELEASE
  } mode_t;

  typedef struct packed {
    logic [NumW-1:0]  num;
    logic [ProdW-1:0] den;
    logic [ProdW-1:0] rem;
    logic [QuoW-1:0]  quo;
    mode_t            mode;
    logic [LvlW-1:0]  direct;
  } div_word_t;

endpackage

// ===== hdl/adsr_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage
// depends on adsr_pkg

module adsr_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  adsr_pkg::div_word_t dat_i,
  output logic               rdy_o,
  output logic               vld_o,
  output adsr_pkg::div_word_t dat_o,
  input  logic               rdy_i
);
  import adsr_pkg::*;

  localparam int Steps = QuoW;

  div_word_t stg_r   [Steps];
  div_word_t stg_nxt [Steps];
  logic      vld_r   [Steps];
  logic      vld_prv [Steps];
  logic [Steps:0] rdy;

  always_comb begin
    div_word_t            prv;
    logic [ProdW:0]       rem_sh;
    logic [ProdW:0]       diff;
    logic                 ge;
    rdy[Steps] = rdy_i;
    for (int j = Steps - 1; j >= 0; j--) begin
      rdy[j] = !vld_r[j] || rdy[j+1];
    end
    for (int j = 0; j < Steps; j++) begin
      if (j == 0) begin
        prv        = dat_i;
        vld_prv[j] = vld_i;
      end else begin
        prv        = stg_r[(j == 0) ? 0 : j-1];
        vld_prv[j] = vld_r[(j == 0) ? 0 : j-1];
      end
      rem_sh = {prv.rem, prv.num[QuoW-1-j]};
      diff   = rem_sh - {1'b0, prv.den};
      ge     = (rem_sh >= {1'b0, prv.den});
      stg_nxt[j]     = prv;
      stg_nxt[j].rem = ge ? diff[ProdW-1:0] : rem_sh[ProdW-1:0];
      stg_nxt[j].quo[QuoW-1-j] = ge;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < Steps; j++) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (rdy[j]) begin
        vld_r[j] <= vld_prv[j];
      end
      if (rdy[j]) begin
        stg_r[j] <= stg_nxt[j];
      end
    end
  end

  assign rdy_o = rdy[0];
  assign vld_o = vld_r[Steps-1];
  assign dat_o = stg_r[Steps-1];

  property p_rem_below_den;
    @(posedge clk) disable iff (!rst_n)
      (vld_o && (dat_o.mode == MODE_ATTACK || dat_o.mode == MODE_DECAY))
        |-> (dat_o.rem < dat_o.den);
  endproperty
  a_rem_below_den: assert property (p_rem_below_den)
    else $error("divider remainder not below divisor");

  property p_attack_bound;
    @(posedge clk) disable iff (!rst_n)
      (vld_o && dat_o.mode == MODE_ATTACK) |-> !dat_o.quo[QuoW-1];
  endproperty
  a_attack_bound: assert property (p_attack_bound)
    else $error("attack quotient reached full scale");

  property p_empty_not_stalling;
    @(posedge clk) disable iff (!rst_n)
      !vld_o |-> rdy[Steps-1];
  endproperty
  a_empty_not_stalling: assert property (p_empty_not_stalling)
    else $error("empty last stage stalls");

endmodule

// ===== hdl/adsr_envelope_level.sv =====
`timescale 1ns / 1ps
// adsr envelope level: piecewise-linear envelope in q1.15 per sample index
// depends on adsr_pkg and adsr_div
// pipeline: 5 setup stages, 16 divider stages and an output register between input
// acceptance and output word; throughput one word per cycle while out_tready does not stall
// the divider takes one quotient bit per stage; stalls propagate per stage
// synchronous active-low reset clears valid bits and sets config registers to their defaults

module adsr_envelope_level #(
  parameter int INDEX_WIDTH = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((INDEX_WIDTH+7)/8)*8-1:0]       in_tdata,   // sample_index
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [adsr_pkg::LvlW-1:0]              out_tdata,  // level
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [adsr_pkg::CfgIdxW-1:0]           cfg_index,
  input  logic [adsr_pkg::NoteW-1:0]             cfg_data
);
  import adsr_pkg::*;

  localparam int CmpW = (INDEX_WIDTH > NoteW) ? INDEX_WIDTH : NoteW;

  logic [FracW-1:0] attack_frac_r, decay_frac_r, sustain_frac_r, release_frac_r;
  logic [LvlW-1:0]  sustain_level_r;
  logic [NoteW-1:0] note_len_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_frac_r   <= '0;
      decay_frac_r    <= '0;
      sustain_frac_r  <= '0;
      release_frac_r  <= '0;
      sustain_level_r <= FullScale;
      note_len_r      <= NoteW'(48000);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegAttack:  attack_frac_r   <= cfg_data[FracW-1:0];
        RegDecay:   decay_frac_r    <= cfg_data[FracW-1:0];
        RegSustain: sustain_frac_r  <= cfg_data[FracW-1:0];
        RegRelease: release_frac_r  <= cfg_data[FracW-1:0];
        RegLevel:   sustain_level_r <= cfg_data[LvlW-1:0];
        RegNote:    note_len_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // stall chain
  logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy_out, div_rdy, div_vld;
  logic v0_r, v1_r, v2_r, v3_r, v4_r, out_v_r;
  div_word_t div_out;

  assign rdy_out   = !out_v_r || out_tready;
  assign rdy4      = !v4_r || div_rdy;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign rdy0      = !v0_r || rdy1;
  assign in_tready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy0)    v0_r    <= in_tvalid;
      if (rdy1)    v1_r    <= v0_r;
      if (rdy2)    v2_r    <= v1_r;
      if (rdy3)    v3_r    <= v2_r;
      if (rdy4)    v4_r    <= v3_r;
      if (rdy_out) out_v_r <= div_vld;
    end
  end

  // stage 0: input word
  logic [INDEX_WIDTH-1:0] idx0_r;
  always_ff @(posedge clk) begin
    if (rdy0) idx0_r <= in_tdata[INDEX_WIDTH-1:0];
  end

  // stage 1: stage bounds and note position
  logic [CmpW-1:0]  idx_ext;
  logic [NoteW-1:0] idx24;
  logic             past1_nxt, end1_nxt;
  logic             past1_r, end1_r;
  logic [ProdW-1:0] p1_r, a1_r, d1_r, s1_r, r1_r;
  logic [NoteW-1:0] tail1_r;

  always_comb begin
    idx_ext   = CmpW'(idx0_r);
    idx24     = idx_ext[NoteW-1:0];
    past1_nxt = idx_ext > CmpW'(note_len_r);
    end1_nxt  = idx24 == note_len_r;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      past1_r <= past1_nxt;
      end1_r  <= end1_nxt;
      p1_r    <= {idx24, {FracW{1'b0}}};
      a1_r    <= ProdW'(attack_frac_r)  * ProdW'(note_len_r);
      d1_r    <= ProdW'(decay_frac_r)   * ProdW'(note_len_r);
      s1_r    <= ProdW'(sustain_frac_r) * ProdW'(note_len_r);
      r1_r    <= ProdW'(release_frac_r) * ProdW'(note_len_r);
      tail1_r <= note_len_r - idx24;
    end
  end

  // stage 2: classify and pick divide operands
  mode_t            mode2_nxt, mode2_r;
  logic [LvlW-1:0]  dir2_nxt, dir2_r;
  logic [FracW-1:0] m1_2_nxt, m1_2_r;
  logic [ProdW-1:0] m2_2_nxt, m2_2_r;
  logic [ProdW-1:0] den2_nxt, den2_r;
  logic             sh2_nxt, sh2_r;

  always_comb begin
    logic [ProdW:0]   ad;
    logic [ProdW+1:0] ads;
    ad        = {1'b0, a1_r} + {1'b0, d1_r};
    ads       = {1'b0, ad} + {2'b00, s1_r};
    mode2_nxt = MODE_DIRECT;
    dir2_nxt  = '0;
    m1_2_nxt  = FullScale;
    m2_2_nxt  = p1_r;
    den2_nxt  = a1_r;
    sh2_nxt   = 1'b0;
    if (past1_r) begin
      mode2_nxt = MODE_DIRECT;
    end else if (p1_r < a1_r) begin
      mode2_nxt = MODE_ATTACK;
    end else if ({1'b0, p1_r} < ad) begin
      m2_2_nxt = p1_r - a1_r;
      den2_nxt = d1_r;
      if (sustain_level_r >= FullScale) begin
        dir2_nxt = FullScale;
      end else begin
        mode2_nxt = MODE_DECAY;
        m1_2_nxt  = FullScale - sustain_level_r;
      end
    end else if ({2'b00, p1_r} < ads) begin
      dir2_nxt = (sustain_level_r > FullScale) ? FullScale : sustain_level_r;
    end else if (r1_r != '0 && !end1_r) begin
      mode2_nxt = MODE_RELEASE;
      m1_2_nxt  = sustain_level_r;
      m2_2_nxt  = ProdW'(tail1_r);
      den2_nxt  = r1_r;
      sh2_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      mode2_r <= mode2_nxt;
      dir2_r  <= dir2_nxt;
      m1_2_r  <= m1_2_nxt;
      m2_2_r  <= m2_2_nxt;
      den2_r  <= den2_nxt;
      sh2_r   <= sh2_nxt;
    end
  end

  // stage 3: partial products
  logic [PartW-1:0] plo3_r, phi3_r;
  mode_t            mode3_r;
  logic [LvlW-1:0]  dir3_r;
  logic [ProdW-1:0] den3_r;
  logic             sh3_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      plo3_r  <= PartW'(m1_2_r) * PartW'(m2_2_r[SegW-1:0]);
      phi3_r  <= PartW'(m1_2_r) * PartW'(m2_2_r[ProdW-1:SegW]);
      mode3_r <= mode2_r;
      dir3_r  <= dir2_r;
      den3_r  <= den2_r;
      sh3_r   <= sh2_r;
    end
  end

  // stage 4: dividend and overflow check
  div_word_t w4_nxt, w4_r;

  always_comb begin
    logic [NumW-1:0] full;
    logic [NumW-1:0] num;
    full = NumW'({phi3_r, {SegW{1'b0}}}) + NumW'(plo3_r);
    num  = sh3_r ? {full[NumW-FracW-1:0], {FracW{1'b0}}} : full;
    w4_nxt.num    = num;
    w4_nxt.den    = den3_r;
    w4_nxt.rem    = num[NumW-1:QuoW];
    w4_nxt.quo    = '0;
    w4_nxt.mode   = mode3_r;
    w4_nxt.direct = dir3_r;
    if (mode3_r == MODE_RELEASE && num[NumW-1:QuoW] >= den3_r) begin
      w4_nxt.mode   = MODE_DIRECT;
      w4_nxt.direct = FullScale;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) w4_r <= w4_nxt;
  end

  adsr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (v4_r),
    .dat_i (w4_r),
    .rdy_o (div_rdy),
    .vld_o (div_vld),
    .dat_o (div_out),
    .rdy_i (rdy_out)
  );

  // output stage
  logic [LvlW-1:0] lvl_nxt, lvl_r;

  always_comb begin
    logic [LvlW:0] drop;
    drop = {1'b0, div_out.quo} + (LvlW+1)'(div_out.rem != '0);
    case (div_out.mode)
      MODE_ATTACK:  lvl_nxt = div_out.quo;
      MODE_DECAY:   lvl_nxt = (drop >= {1'b0, FullScale}) ? '0
                                : FullScale - drop[LvlW-1:0];
      MODE_RELEASE: lvl_nxt = (div_out.quo > FullScale) ? FullScale : div_out.quo;
      default:      lvl_nxt = div_out.direct;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy_out) lvl_r <= lvl_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = lvl_r;

  property p_level_range;
    @(posedge clk) disable iff (!rst_n)
      out_tvalid |-> (out_tdata <= FullScale);
  endproperty
  a_level_range: assert property (p_level_range)
    else $error("level above full scale");

  property p_empty_accepts;
    @(posedge clk) disable iff (!rst_n)
      !out_v_r |-> in_tready;
  endproperty
  a_empty_accepts: assert property (p_empty_accepts)
    else $error("input blocked with empty output stage");

  property p_reset_clears;
    @(posedge clk) !rst_n |=> !out_tvalid;
  endproperty
  a_reset_clears: assert property (p_reset_clears)
    else $error("output valid right after reset");

endmodule

// ===== tb/adsr_envelope_level_tb.sv =====
`timescale 1ns / 1ps
// testbench for adsr_envelope_level: directed table, then random config phases and indices,
// every output word checked against a table level or an in-bench envelope predictor
// depends on adsr_pkg and the adsr_envelope_level rtl

module adsr_envelope_level_tb;
  import adsr_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpare6  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare7  = 3'd7;
  localparam int DrainCycles = 40;
  localparam int QuietLimit  = 3000;
  localparam int PhaseCount  = 10;
  localparam int PhaseItems  = 100;

  typedef struct {
    bit                 is_cfg;
    logic [CfgIdxW-1:0] reg_idx;
    logic [NoteW-1:0]   value;
    bit                 typed;
    logic [LvlW-1:0]    level;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [23:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [LvlW-1:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [NoteW-1:0] cfg_data;

  // predictor copy of the registers
  logic [FracW-1:0] attack_q, decay_q, sustain_q, release_q, level_q;
  logic [NoteW-1:0] note_q;

  logic [LvlW-1:0] level_fifo[$];
  row_t rows[$];
  int fails = 0;
  int quiet = 0;

  adsr_envelope_level #(.INDEX_WIDTH(24)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned clamp_full(longint unsigned v);
    return (v > 64'd32768) ? 64'd32768 : v;
  endfunction

  function automatic logic [LvlW-1:0] envelope_level(logic [23:0] idx);
    longint unsigned n, a, d, s, r, p, sl, t, num, drop;
    n  = note_q;
    a  = attack_q * n;
    d  = decay_q * n;
    s  = sustain_q * n;
    r  = release_q * n;
    p  = longint'(idx) << 16;
    sl = level_q;
    if (idx > n) return '0;
    if (p < a) return LvlW'(clamp_full((p * 32768) / a));
    if (p < a + d) begin
      t = p - a;
      if (sl >= 32768) return FullScale;
      num  = (32768 - sl) * t;
      drop = (num + d - 1) / d;
      return (drop >= 32768) ? '0 : LvlW'(32768 - drop);
    end
    if (p < a + d + s) return LvlW'(clamp_full(sl));
    if (r == 0 || idx >= n) return '0;
    return LvlW'(clamp_full(((sl * (n - idx)) << 16) / r));
  endfunction

  task automatic report(input string what, input logic [LvlW-1:0] got,
                        input logic [LvlW-1:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fails++;
  endtask

  function automatic int gap_draw();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  // result side stalls
  initial begin
    int n;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      n = gap_draw();
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  // output check and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (out_tvalid && out_tready) begin
        if (level_fifo.size() == 0)
          report("unexpected word", out_tdata, '0);
        else if (out_tdata !== level_fifo[0]) begin
          report("level", out_tdata, level_fifo[0]);
          void'(level_fifo.pop_front());
        end else
          void'(level_fifo.pop_front());
      end
      if (quiet >= QuietLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [NoteW-1:0] val);
    while (level_fifo.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      RegAttack:  attack_q  = val[FracW-1:0];
      RegDecay:   decay_q   = val[FracW-1:0];
      RegSustain: sustain_q = val[FracW-1:0];
      RegRelease: release_q = val[FracW-1:0];
      RegLevel:   level_q   = val[FracW-1:0];
      RegNote:    note_q    = val;
      default: ;
    endcase
  endtask

  task automatic send_index(input logic [23:0] idx, input bit typed,
                            input logic [LvlW-1:0] want);
    int n;
    n = gap_draw();
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= idx;
    @(posedge clk);
    while (!(in_tvalid && in_tready)) @(posedge clk);
    level_fifo.push_back(typed ? want : envelope_level(idx));
  endtask

  task automatic idle_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [NoteW-1:0] val);
    row_t r;
    r = '{1'b1, idx, val, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t item_row(logic [23:0] idx, bit typed, logic [LvlW-1:0] lvl);
    row_t r;
    r = '{1'b0, '0, idx, typed, lvl};
    return r;
  endfunction

  task automatic random_phase();
    int kind;
    logic [FracW-1:0] f[4];
    logic [NoteW-1:0] n;
    logic [23:0] idx;
    kind = $urandom_range(0, 4);
    for (int k = 0; k < 4; k++) begin
      case (kind)
        0: f[k] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        1: f[k] = 16'($urandom);
        default: f[k] = 16'($urandom_range(0, 24000));
      endcase
    end
    case ($urandom_range(0, 7))
      0: n = 24'hFFFFFF;
      1: n = 24'd1;
      2: n = 24'd0;
      default: n = 24'($urandom_range(2, 4000));
    endcase
    write_reg(RegAttack,  {8'($urandom_range(0, 255)), f[0]});
    write_reg(RegDecay,   {8'($urandom_range(0, 255)), f[1]});
    write_reg(RegSustain, {8'($urandom_range(0, 255)), f[2]});
    write_reg(RegRelease, {8'($urandom_range(0, 255)), f[3]});
    write_reg(RegLevel,   {8'($urandom_range(0, 255)),
                           16'($urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 32768))});
    write_reg(RegNote, n);
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? RegSpare6 : RegSpare7, 24'($urandom));
    for (int i = 0; i < PhaseItems; i++) begin
      if ($urandom_range(0, 9) == 0) idx = 24'($urandom);
      else idx = 24'($urandom_range(0, n + 2));
      send_index(idx, 1'b0, '0);
    end
    idle_input();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    attack_q  = '0;
    decay_q   = '0;
    sustain_q = '0;
    release_q = '0;
    level_q   = 16'd32768;
    note_q    = 24'd48000;
    // after reset all stage fractions are zero, so all levels are zero
    rows.push_back(item_row(24'd0, 1'b1, 16'd0));
    rows.push_back(item_row(24'd48000, 1'b1, 16'd0));
    rows.push_back(item_row(24'd48001, 1'b1, 16'd0));
    rows.push_back(item_row(24'hFFFFFF, 1'b1, 16'd0));
    // quarter stages, half level, short note
    rows.push_back(cfg_row(RegAttack, 24'd16384));
    rows.push_back(cfg_row(RegDecay, 24'd16384));
    rows.push_back(cfg_row(RegSustain, 24'd16384));
    rows.push_back(cfg_row(RegRelease, 24'd16384));
    rows.push_back(cfg_row(RegLevel, 24'd16384));
    rows.push_back(cfg_row(RegNote, 24'd1000));
    rows.push_back(item_row(24'd0, 1'b1, 16'd0));
    rows.push_back(item_row(24'd100, 1'b0, '0));
    rows.push_back(item_row(24'd250, 1'b1, 16'd32768));
    rows.push_back(item_row(24'd400, 1'b0, '0));
    rows.push_back(item_row(24'd500, 1'b1, 16'd16384));
    rows.push_back(item_row(24'd900, 1'b0, '0));
    rows.push_back(item_row(24'd1000, 1'b1, 16'd0));
    rows.push_back(item_row(24'd1001, 1'b1, 16'd0));
    // level above full scale saturates; unknown index ignored
    rows.push_back(cfg_row(RegLevel, 24'hFFFFFF));
    rows.push_back(cfg_row(RegSpare7, 24'd0));
    rows.push_back(item_row(24'd500, 1'b1, 16'd32768));
    rows.push_back(item_row(24'd800, 1'b0, '0));
    // zero note length
    rows.push_back(cfg_row(RegNote, 24'd0));
    rows.push_back(item_row(24'd0, 1'b1, 16'd0));
    rows.push_back(item_row(24'd1, 1'b1, 16'd0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        idle_input();
        write_reg(rows[i].reg_idx, rows[i].value);
      end else
        send_index(rows[i].value, rows[i].typed, rows[i].level);
    end
    idle_input();
    for (int ph = 0; ph < PhaseCount; ph++) random_phase();

    while (level_fifo.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fails == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/adsr_pkg.sv
hdl/adsr_div.sv
hdl/adsr_envelope_level.sv
tb/adsr_envelope_level_tb.sv
